>>> hdl/q2e_pkg.sv
// shared types, constants and the arctangent table for the quaternion to euler block
// no dependencies
`timescale 1ns / 1ps

package q2e_pkg;

   localparam int NORM_TOP_BIT = 14;
   localparam int PRESCALE_SHIFT = 28;
   localparam int SQRT_STEPS = 32;
   localparam logic signed [31:0] DEG90_Q16 = 32'sd5898240;
   localparam logic signed [15:0] PITCH_LIM = 16'sd11520;
   localparam logic signed [15:0] ANGLE_LIM = 16'sd23040;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [14:0] pitch_deg;
      logic signed [15:0] yaw_deg;
      logic signed [15:0] roll_deg;
      logic               gimbal_lock;
   } rsp_type;

   typedef struct packed {
      logic [63:0] v;
      logic [63:0] r;
   } sqrt_type;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [31:0] z;
      logic               zero;
   } cordic_type;

   typedef struct packed {
      logic lock;
      logic neg;
      logic nz;
   } flag_type;

   // atan(2^-i) in degrees, q16, rounded to nearest
   function automatic logic signed [31:0] atan_q16(input int i);
      logic signed [31:0] v;
      case (i)
         0: v = 32'sd2949120;
         1: v = 32'sd1740967;
         2: v = 32'sd919879;
         3: v = 32'sd466945;
         4: v = 32'sd234379;
         5: v = 32'sd117304;
         6: v = 32'sd58666;
         7: v = 32'sd29335;
         8: v = 32'sd14668;
         9: v = 32'sd7334;
         10: v = 32'sd3667;
         11: v = 32'sd1833;
         12: v = 32'sd917;
         13: v = 32'sd458;
         14: v = 32'sd229;
         15: v = 32'sd115;
         16: v = 32'sd57;
         17: v = 32'sd29;
         18: v = 32'sd14;
         19: v = 32'sd7;
         20: v = 32'sd4;
         21: v = 32'sd2;
         22: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

>>> hdl/q2e_sqrt_cell.sv
// one step of the digit-by-digit integer square root, one result bit per step
// depends on q2e_pkg
`timescale 1ns / 1ps

module q2e_sqrt_cell import q2e_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  sqrt_type step_in,
   output sqrt_type step_out
);

   localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

   sqrt_type step_ff;
   sqrt_type step_in_nx;
   logic [63:0] trial;

   always_comb begin
      trial = step_in.r + BIT;
      if (step_in.v >= trial) begin
         step_in_nx.v = step_in.v - trial;
         step_in_nx.r = (step_in.r >> 1) + BIT;
      end else begin
         step_in_nx.v = step_in.v;
         step_in_nx.r = step_in.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in_nx;
   end

   assign step_out = step_ff;

endmodule

>>> hdl/q2e_cordic_cell.sv
// one vectoring cordic micro-rotation with a registered output
// depends on q2e_pkg
`timescale 1ns / 1ps

module q2e_cordic_cell import q2e_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  cordic_type rot_in,
   output cordic_type rot_out
);

   localparam logic signed [31:0] ANGLE = atan_q16(STAGE);

   cordic_type rot_ff;
   cordic_type rot_nx;
   logic signed [63:0] xs;
   logic signed [63:0] ys;

   always_comb begin
      xs = rot_in.x >>> STAGE;
      ys = rot_in.y >>> STAGE;
      rot_nx.zero = rot_in.zero;
      if (!rot_in.y[63]) begin
         rot_nx.x = rot_in.x + ys;
         rot_nx.y = rot_in.y - xs;
         rot_nx.z = rot_in.z + ANGLE;
      end else begin
         rot_nx.x = rot_in.x - ys;
         rot_nx.y = rot_in.y + xs;
         rot_nx.z = rot_in.z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_nx;
   end

   assign rot_out = rot_ff;

endmodule

>>> hdl/quaternion_to_euler_angles.sv
// quaternion to pitch, yaw and roll in degrees q7, fully pipelined
// depends on q2e_pkg, q2e_sqrt_cell, q2e_cordic_cell
`timescale 1ns / 1ps

//  channel   ports                        handshake
//  request   start, busy, req_data        taken when start high and busy low
//  response  rsp_valid, rsp_data          one-cycle strobe, cannot be held off
//
//  one transaction enters every cycle while reset is low; results leave in the same order
//  the pipe is six front stages, 32 square root cells,
//  one multiply, one pre-rotation and the cordic cell chain, one output stage
//  busy is high only while reset is held; reset clears the valid line only
//  the response side has no stall, so nothing in the pipe ever waits

module quaternion_to_euler_angles import q2e_pkg::*; #(
   parameter int CORDIC_STAGES = 16,
   parameter int COMPONENT_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CB = COMPONENT_BITS;
   localparam int NW = COMPONENT_BITS + 16;
   localparam int TW = $clog2(COMPONENT_BITS);
   localparam int LAT = CORDIC_STAGES + 41;

   // valid line, one bit per pipeline register
   logic [LAT-1:0] valid_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], start && !busy};
      end
   end

   // stage 1: field truncation to COMPONENT_BITS
   logic signed [CB-1:0] q1_ff [4];
   logic signed [CB-1:0] q1_in [4];
   logic [CB+15:0] raw_w, raw_x, raw_y, raw_z;

   always_comb begin
      raw_w = {{CB{1'b0}}, req_data.quat_w};
      raw_x = {{CB{1'b0}}, req_data.quat_x};
      raw_y = {{CB{1'b0}}, req_data.quat_y};
      raw_z = {{CB{1'b0}}, req_data.quat_z};
      q1_in[0] = raw_w[CB-1:0];
      q1_in[1] = raw_x[CB-1:0];
      q1_in[2] = raw_y[CB-1:0];
      q1_in[3] = raw_z[CB-1:0];
   end

   always_ff @(posedge clock) begin
      q1_ff <= q1_in;
   end

   // stage 2: leading one of the largest magnitude (same as of the or of all)
   logic signed [CB-1:0] q2_ff [4];
   logic [TW-1:0] top_ff, top_in;
   logic nz2_ff, nz2_in;
   logic [CB-1:0] mag_or;

   always_comb begin
      mag_or = '0;
      for (int k = 0; k < 4; k++) begin
         mag_or = mag_or | (q1_ff[k][CB-1] ? CB'(-q1_ff[k]) : CB'(q1_ff[k]));
      end
      top_in = '0;
      for (int i = 0; i < CB; i++) begin
         if (mag_or[i]) begin
            top_in = TW'(i);
         end
      end
      nz2_in = |mag_or;
   end

   always_ff @(posedge clock) begin
      q2_ff <= q1_ff;
      top_ff <= top_in;
      nz2_ff <= nz2_in;
   end

   // stage 3: block scaling so the top bit sits at bit 14
   logic signed [15:0] q3_ff [4];
   logic signed [15:0] q3_in [4];
   logic nz3_ff;
   logic [5:0] rs, ls;
   logic signed [NW-1:0] qe;
   logic signed [NW-1:0] qs;

   always_comb begin
      rs = 6'(top_ff) - 6'(NORM_TOP_BIT);
      ls = 6'(NORM_TOP_BIT) - 6'(top_ff);
      qe = '0;
      qs = '0;
      for (int k = 0; k < 4; k++) begin
         qe = {{16{q2_ff[k][CB-1]}}, q2_ff[k]};
         if (6'(top_ff) > 6'(NORM_TOP_BIT)) begin
            qs = qe >>> rs;
         end else begin
            qs = qe <<< ls;
         end
         q3_in[k] = qs[15:0];
      end
   end

   always_ff @(posedge clock) begin
      q3_ff <= q3_in;
      nz3_ff <= nz2_ff;
   end

   // stage 4: the ten products
   logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_xw, p_yz, p_xz, p_yw, p_xy, p_zw;
   logic nz4_ff;

   always_ff @(posedge clock) begin
      p_ww <= q3_ff[0] * q3_ff[0];
      p_xx <= q3_ff[1] * q3_ff[1];
      p_yy <= q3_ff[2] * q3_ff[2];
      p_zz <= q3_ff[3] * q3_ff[3];
      p_xw <= q3_ff[1] * q3_ff[0];
      p_yz <= q3_ff[2] * q3_ff[3];
      p_xz <= q3_ff[1] * q3_ff[3];
      p_yw <= q3_ff[2] * q3_ff[0];
      p_xy <= q3_ff[1] * q3_ff[2];
      p_zw <= q3_ff[3] * q3_ff[0];
      nz4_ff <= nz3_ff;
   end

   // stage 5: norm and the atan2 arguments, exact integers
   logic signed [35:0] n_ff, a_ff, ya_ff, yb_ff, rc_ff, rd_ff, le_ff, lf_ff;
   logic nz5_ff;

   always_ff @(posedge clock) begin
      n_ff  <= 36'(p_ww) + 36'(p_xx) + 36'(p_yy) + 36'(p_zz);
      a_ff  <= (36'(p_xw) - 36'(p_yz)) <<< 1;
      ya_ff <= (36'(p_xz) + 36'(p_yw)) <<< 1;
      yb_ff <= 36'(p_ww) - 36'(p_xx) - 36'(p_yy) + 36'(p_zz);
      rc_ff <= (36'(p_xy) + 36'(p_zw)) <<< 1;
      rd_ff <= 36'(p_ww) - 36'(p_xx) + 36'(p_yy) - 36'(p_zz);
      le_ff <= (36'(p_zw) - 36'(p_xy)) <<< 1;
      lf_ff <= 36'(p_ww) + 36'(p_xx) - 36'(p_yy) - 36'(p_zz);
      nz5_ff <= nz4_ff;
   end

   // stage 6: gimbal lock test, square root operands, prescaled cordic inputs
   sqrt_type sq1_ff, sq2_ff;
   logic signed [63:0] py_ff [SQRT_STEPS+1];
   logic signed [63:0] yy_ff [SQRT_STEPS+1];
   logic signed [63:0] yx_ff [SQRT_STEPS+1];
   logic signed [63:0] ry_ff [SQRT_STEPS+1];
   logic signed [63:0] rx_ff [SQRT_STEPS+1];
   flag_type fs_ff [SQRT_STEPS+1];
   logic lock6;

   assign lock6 = (a_ff >= n_ff) || (a_ff <= -n_ff);

   always_ff @(posedge clock) begin
      sq1_ff.v <= 64'(n_ff - a_ff) << PRESCALE_SHIFT;
      sq1_ff.r <= '0;
      sq2_ff.v <= 64'(n_ff + a_ff) << PRESCALE_SHIFT;
      sq2_ff.r <= '0;
      py_ff[0] <= 64'(a_ff) <<< PRESCALE_SHIFT;
      yy_ff[0] <= 64'(lock6 ? le_ff : ya_ff) <<< PRESCALE_SHIFT;
      yx_ff[0] <= 64'(lock6 ? lf_ff : yb_ff) <<< PRESCALE_SHIFT;
      ry_ff[0] <= 64'(rc_ff) <<< PRESCALE_SHIFT;
      rx_ff[0] <= 64'(rd_ff) <<< PRESCALE_SHIFT;
      fs_ff[0].lock <= lock6;
      fs_ff[0].neg <= a_ff[35];
      fs_ff[0].nz <= nz5_ff;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         py_ff[k+1] <= py_ff[k];
         yy_ff[k+1] <= yy_ff[k];
         yx_ff[k+1] <= yx_ff[k];
         ry_ff[k+1] <= ry_ff[k];
         rx_ff[k+1] <= rx_ff[k];
         fs_ff[k+1] <= fs_ff[k];
      end
   end

   // square root cell chains for sqrt((n-a) 2^28) and sqrt((n+a) 2^28)
   sqrt_type sq1 [SQRT_STEPS+1];
   sqrt_type sq2 [SQRT_STEPS+1];

   assign sq1[0] = sq1_ff;
   assign sq2[0] = sq2_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      q2e_sqrt_cell #(.STEP(g)) u_sq1 (
         .clock    (clock),
         .step_in  (sq1[g]),
         .step_out (sq1[g+1])
      );
      q2e_sqrt_cell #(.STEP(g)) u_sq2 (
         .clock    (clock),
         .step_in  (sq2[g]),
         .step_out (sq2[g+1])
      );
   end

   // multiply: cos(pitch) scaled, product of the two roots
   logic signed [63:0] c_ff;
   logic signed [63:0] pym_ff, yym_ff, yxm_ff, rym_ff, rxm_ff;
   flag_type fm_ff;

   always_ff @(posedge clock) begin
      c_ff <= 64'(sq1[SQRT_STEPS].r[31:0] * sq2[SQRT_STEPS].r[31:0]);
      pym_ff <= py_ff[SQRT_STEPS];
      yym_ff <= yy_ff[SQRT_STEPS];
      yxm_ff <= yx_ff[SQRT_STEPS];
      rym_ff <= ry_ff[SQRT_STEPS];
      rxm_ff <= rx_ff[SQRT_STEPS];
      fm_ff <= fs_ff[SQRT_STEPS];
   end

   // pre-rotation by 90 degrees for a vector in the left half plane
   function automatic cordic_type prerot(input logic signed [63:0] y,
                                         input logic signed [63:0] x);
      cordic_type r;
      r.zero = (x == '0) && (y == '0);
      if (x[63]) begin
         if (!y[63]) begin
            r.x = y;
            r.y = -x;
            r.z = DEG90_Q16;
         end else begin
            r.x = -y;
            r.y = x;
            r.z = -DEG90_Q16;
         end
      end else begin
         r.x = x;
         r.y = y;
         r.z = '0;
      end
      return r;
   endfunction

   cordic_type cp [CORDIC_STAGES+1];
   cordic_type cy [CORDIC_STAGES+1];
   cordic_type cr [CORDIC_STAGES+1];
   cordic_type cp_ff, cy_ff, cr_ff;
   flag_type fc_ff [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      cp_ff <= prerot(pym_ff, c_ff);
      cy_ff <= prerot(yym_ff, yxm_ff);
      cr_ff <= prerot(rym_ff, rxm_ff);
      fc_ff[0] <= fm_ff;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         fc_ff[k+1] <= fc_ff[k];
      end
   end

   assign cp[0] = cp_ff;
   assign cy[0] = cy_ff;
   assign cr[0] = cr_ff;

   // three cordic chains side by side: pitch, yaw, roll
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      q2e_cordic_cell #(.STAGE(g)) u_pitch (
         .clock   (clock),
         .rot_in  (cp[g]),
         .rot_out (cp[g+1])
      );
      q2e_cordic_cell #(.STAGE(g)) u_yaw (
         .clock   (clock),
         .rot_in  (cy[g]),
         .rot_out (cy[g+1])
      );
      q2e_cordic_cell #(.STAGE(g)) u_roll (
         .clock   (clock),
         .rot_in  (cr[g]),
         .rot_out (cr[g+1])
      );
   end

   // q16 to q7 with ties up, then clamp
   function automatic logic signed [15:0] to_q7(input logic signed [31:0] z,
                                                input logic signed [15:0] lim);
      logic signed [31:0] r;
      r = (z + 32'sd256) >>> 9;
      if (r > 32'(lim)) begin
         r = 32'(lim);
      end
      if (r < -32'(lim)) begin
         r = -32'(lim);
      end
      return r[15:0];
   endfunction

   // output stage
   rsp_type rsp_ff, rsp_in;
   flag_type fo;
   logic signed [31:0] zp, zy, zr;
   logic signed [15:0] pq;

   always_comb begin
      fo = fc_ff[CORDIC_STAGES];
      zp = cp[CORDIC_STAGES].zero ? '0 : cp[CORDIC_STAGES].z;
      zy = cy[CORDIC_STAGES].zero ? '0 : cy[CORDIC_STAGES].z;
      zr = cr[CORDIC_STAGES].zero ? '0 : cr[CORDIC_STAGES].z;
      if (fo.lock && fo.neg) begin
         zy = -zy;
      end
      pq = to_q7(zp, PITCH_LIM);
      if (fo.lock) begin
         pq = fo.neg ? -PITCH_LIM : PITCH_LIM;
      end
      rsp_in.pitch_deg = fo.nz ? pq[14:0] : '0;
      rsp_in.yaw_deg = fo.nz ? to_q7(zy, ANGLE_LIM) : '0;
      rsp_in.roll_deg = (fo.nz && !fo.lock) ? to_q7(zr, ANGLE_LIM) : '0;
      rsp_in.gimbal_lock = fo.nz && fo.lock;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = valid_ff[LAT-1];

endmodule

>>> hdl/q2e_checker.sv
// port-level assertions for the quaternion to euler block, bound to the top level
// depends on q2e_pkg and quaternion_to_euler_angles
`timescale 1ns / 1ps

module q2e_assert import q2e_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // gimbal lock means pitch pinned at +/-90 and roll zero
   a_lock_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.gimbal_lock |->
         rsp_data.roll_deg == '0 &&
         (rsp_data.pitch_deg == 15'(PITCH_LIM) || rsp_data.pitch_deg == -15'(PITCH_LIM)))
      else $error("gimbal lock response malformed");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pitch_deg >= -15'(PITCH_LIM) &&
                    rsp_data.pitch_deg <= 15'(PITCH_LIM))
      else $error("pitch out of range");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.yaw_deg >= -ANGLE_LIM && rsp_data.yaw_deg <= ANGLE_LIM &&
                    rsp_data.roll_deg >= -ANGLE_LIM && rsp_data.roll_deg <= ANGLE_LIM)
      else $error("yaw or roll out of range");

   // the pipe is empty right after reset
   a_reset_flush: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response strobe right after reset");

endmodule

bind quaternion_to_euler_angles q2e_assert u_q2e_assert (.*);

>>> tb/q2e_checker.sv
// checker for the quaternion to euler block: predicts every transaction and compares
// depends on q2e_pkg
`timescale 1ns / 1ps

module q2e_checker import q2e_pkg::*; #(
   parameter int CORDIC_STAGES = 16,
   parameter int COMPONENT_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   rsp_type angle_queue[$];

   assign pending = angle_queue.size();

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // vectoring cordic, degrees q16
   function automatic longint angle_q16(input longint y, input longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = DEG90_Q16;
         end else begin
            x = -y; y = t; z = -DEG90_Q16;
         end
      end
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += longint'(atan_q16(i));
         end else begin
            x -= ys; y += xs; z -= longint'(atan_q16(i));
         end
      end
      return z;
   endfunction

   function automatic longint round_q7(input longint z, input longint lim);
      longint r;
      r = (z + 256) >>> 9;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic rsp_type predict_angles(input req_type q);
      longint c[4], m, mag, n, a, w, x, y, zc, e, f, ang, cs;
      longint unsigned r1, r2;
      int top;
      logic [15:0] raw[4];
      logic [63:0] v;
      rsp_type o;
      o = '0;
      raw[0] = q.quat_w; raw[1] = q.quat_x; raw[2] = q.quat_y; raw[3] = q.quat_z;
      m = 0;
      top = -1;
      for (int k = 0; k < 4; k++) begin
         v = 64'(raw[k]) & ((64'd1 << COMPONENT_BITS) - 1);
         if (v[COMPONENT_BITS-1]) v = v | ~((64'd1 << COMPONENT_BITS) - 1);
         c[k] = longint'(v);
         mag = c[k] < 0 ? -c[k] : c[k];
         if (mag > m) m = mag;
      end
      for (int k = 0; k < 63; k++) if (m[k]) top = k;
      if (top < 0) return o;
      for (int k = 0; k < 4; k++) begin
         if (top > NORM_TOP_BIT) c[k] = c[k] >>> (top - NORM_TOP_BIT);
         else c[k] = c[k] <<< (NORM_TOP_BIT - top);
      end
      w = c[0]; x = c[1]; y = c[2]; zc = c[3];
      n = w*w + x*x + y*y + zc*zc;
      a = 2 * (x*w - y*zc);
      if (a >= n || a <= -n) begin
         e = 2 * (zc*w - x*y);
         f = n - 2 * (y*y + zc*zc);
         ang = angle_q16(e <<< 28, f <<< 28);
         o.gimbal_lock = 1'b1;
         if (a < 0) begin
            o.pitch_deg = -15'(PITCH_LIM);
            ang = -ang;
         end else begin
            o.pitch_deg = 15'(PITCH_LIM);
         end
         o.yaw_deg = 16'(round_q7(ang, ANGLE_LIM));
      end else begin
         r1 = root_floor(64'(n - a) << 28);
         r2 = root_floor(64'(n + a) << 28);
         cs = longint'(r1 * r2);
         o.pitch_deg = 15'(round_q7(angle_q16(a <<< 28, cs), PITCH_LIM));
         o.yaw_deg = 16'(round_q7(angle_q16((2*(x*zc + y*w)) <<< 28,
                                            (n - 2*(x*x + y*y)) <<< 28), ANGLE_LIM));
         o.roll_deg = 16'(round_q7(angle_q16((2*(x*y + zc*w)) <<< 28,
                                             (n - 2*(x*x + zc*zc)) <<< 28), ANGLE_LIM));
      end
      return o;
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && start && !busy) angle_queue.push_back(predict_angles(req_data));
      if (!reset && rsp_valid) begin
         if (angle_queue.size() == 0) begin
            $error("unexpected result transaction");
            fail_count++;
         end else begin
            want = angle_queue.pop_front();
            if (rsp_data.pitch_deg !== want.pitch_deg) begin
               $error("pitch_deg expected %0d actual %0d", want.pitch_deg, rsp_data.pitch_deg);
               fail_count++;
            end
            if (rsp_data.yaw_deg !== want.yaw_deg) begin
               $error("yaw_deg expected %0d actual %0d", want.yaw_deg, rsp_data.yaw_deg);
               fail_count++;
            end
            if (rsp_data.roll_deg !== want.roll_deg) begin
               $error("roll_deg expected %0d actual %0d", want.roll_deg, rsp_data.roll_deg);
               fail_count++;
            end
            if (rsp_data.gimbal_lock !== want.gimbal_lock) begin
               $error("gimbal_lock expected %0b actual %0b", want.gimbal_lock,
                      rsp_data.gimbal_lock);
               fail_count++;
            end
         end
      end
   end

endmodule

>>> tb/tb_top.sv
// stimulus and verdict for the quaternion to euler block
// depends on q2e_pkg, quaternion_to_euler_angles, q2e_checker
`timescale 1ns / 1ps

module tb_top;
   import q2e_pkg::*;

   localparam int LATENCY = 16 + 41;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycles = 0;
   int      idle_pct = 0;

   always #5 clock = ~clock;

   quaternion_to_euler_angles uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   q2e_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending(pending)
   );

   // watchdog on total run length
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // present one transaction at the falling edge, hold it until taken
   task automatic send_quat(input req_type q);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic rest;
      @(negedge clock);
      start <= 1'b0;
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(8)) - 4);
         3: return 16'($urandom) >>> $urandom_range(15);
         default: return 16'($urandom);
      endcase
   endfunction

   // random quaternion; some lie on the gimbal-lock boundary
   function automatic req_type random_quat();
      req_type q;
      logic [15:0] s;
      q = {pick_value(), pick_value(), pick_value(), pick_value()};
      if ($urandom_range(9) < 2) begin
         // x = +/-w with z = -/+y makes 2*(x*w - y*z) = +/-(w*w + x*x + y*y + z*z), pitch +/-90
         s = 16'($urandom) >>> $urandom_range(15);
         q.quat_x = $urandom_range(1) ? q.quat_w : -q.quat_w;
         q.quat_z = (q.quat_x == q.quat_w) ? -s : s;
         q.quat_y = s;
      end
      return q;
   endfunction

   initial begin
      req_type directed[$];
      directed = '{
         '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
         '{16'sd1, 16'sd0, 16'sd0, 16'sd0},
         '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0},
         '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
         '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
         '{16'sd1000, 16'sd1000, 16'sd0, 16'sd0},
         '{16'sd1000, -16'sd1000, 16'sd0, 16'sd0},
         '{16'sd5, 16'sd5, 16'sd3, -16'sd3},
         '{16'sd0, 16'sd0, 16'sd1, 16'sd0},
         '{16'sd0, 16'sd0, 16'sd0, 16'sd1},
         '{16'sd0, 16'sd1, 16'sd0, 16'sd0},
         '{16'sd0, 16'sd1, 16'sd1, 16'sd0},
         '{-16'sd7, 16'sd3, 16'sd12345, -16'sd21000},
         '{16'sd21845, 16'sd0, -16'sd21845, 16'sd1},
         '{16'sd1, 16'sd1, -16'sd1, 16'sd1},
         '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa},
         '{16'haaaa, 16'h5555, 16'haaaa, 16'h5555}
      };
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_quat(directed[i]);
      rest();

      // sender pauses until the pipe drains
      while (pending != 0) @(posedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 74 : (phase == 3) ? 27 : 0;
         for (int i = 0; i < 410; i++) send_quat(random_quat());
         rest();
      end

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
